/* rtl/cpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET = 32'h4D48_5558;
  localparam logic [16:0] LEN_CAP     = 17'h1_0000;
  localparam int          LEN_CAP_INT = 65536;

  localparam int HEADER_BYTES = 18;
  localparam int CHECK_BYTES  = 4;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_OK       = 3'd1;
  localparam logic [2:0] KIND_MAGIC    = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_LENGTH   = 3'd4;

  // configuration register indexes
  localparam logic CFG_MAGIC = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic        frame_end;
    logic [15:0] version;
    logic [15:0] ftype;
    logic [15:0] status;
    logic [31:0] seqno;
    logic [16:0] length;
  } result_t;

endpackage

/* rtl/crc32_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_packet_deframer
// Framed byte stream receiver with crc-32 check and payload forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one stream byte per request (rx_valid / rx_stall).
//   result channel: payload bytes (kind 0) as they arrive, and one status
//   request (frame_end high) closing each frame: ok, bad magic, checksum
//   mismatch or length over limit. Drop the forwarded payload on an error.
//   Header fields ride along on every result.
//   cfg channel: cfg_index 0 writes the expected magic, 1 the payload limit;
//   cfg_ready is always high. Write only while no frame is in flight.
// Timing:
//   one byte per cycle sustained while the output register is not stalled;
//   a byte enters an input register, the per-byte crc and frame logic are
//   combinational, and the result lands in an output register.
// Reset: frame state returns to header collection, crc to all ones, magic
//   and limit to their defaults. No clearing pass is needed.
// Stall: while result_stall holds a full output register, the input
//   register holds its byte and rx_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module crc32_packet_deframer #(
  parameter int MAX_PAYLOAD = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic        frame_end,
  output logic [15:0] frame_version,
  output logic [15:0] frame_type,
  output logic [15:0] frame_status,
  output logic [31:0] frame_sequence,
  output logic [16:0] frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import cpd_pkg::*;

  localparam int EFF_MAX   = (MAX_PAYLOAD < LEN_CAP_INT) ? MAX_PAYLOAD : LEN_CAP_INT;
  localparam int LIM_W     = $clog2(EFF_MAX + 1);
  localparam int CNT_W     = (LIM_W > 5) ? LIM_W : 5;
  localparam logic [16:0] EFF_MAX_W = 17'(EFF_MAX);

  logic [31:0] expected_magic;
  logic [16:0] payload_limit;
  logic [16:0] limit_cap, eff_limit;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;
  result_t     res;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= MAGIC_RESET;
      payload_limit  <= LEN_CAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC: expected_magic <= cfg_data;
        CFG_LIMIT: payload_limit  <= cfg_data[16:0];
      endcase
    end
  end

  assign limit_cap = (payload_limit > LEN_CAP) ? LEN_CAP : payload_limit;
  assign eff_limit = (EFF_MAX_W < limit_cap) ? EFF_MAX_W : limit_cap;

  // input register
  assign advance  = in_full && (!result_valid || !result_stall);
  assign rx_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!rx_stall) begin
      in_full <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  cpd_frame_ctl #(
    .CNT_W (CNT_W)
  ) u_ctl (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .rx_byte        (in_byte),
    .expected_magic (expected_magic),
    .eff_limit      (eff_limit),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res.valid) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      result_kind    <= res.kind;
      payload_byte   <= res.payload;
      frame_end      <= res.frame_end;
      frame_version  <= res.version;
      frame_type     <= res.ftype;
      frame_status   <= res.status;
      frame_sequence <= res.seqno;
      frame_length   <= res.length;
    end
  end

  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_end == (result_kind != KIND_PAYLOAD))
    else $error("frame_end disagrees with result kind");

  a_status_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("status result carries payload data");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("held input byte lost while output was stalled");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_length <= LEN_CAP)
    else $error("frame length not saturated");

endmodule

/* rtl/cpd_crc_byte.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_crc_byte
// One-byte update of a reflected crc-32, bit by bit over eight xor levels.
// ----------------------------------------------------------------------------
module cpd_crc_byte (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_next
);
  import cpd_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_next = c;
  end

endmodule

/* rtl/cpd_frame_ctl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_frame_ctl
// Frame state: header collection, payload forwarding and checksum compare.
// ----------------------------------------------------------------------------
module cpd_frame_ctl #(
  parameter int CNT_W = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic [31:0]     expected_magic,
  input  logic [16:0]     eff_limit,
  output cpd_pkg::result_t res
);
  import cpd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next, count_inc;
  logic [31:0]      running_crc, running_crc_next, crc_upd;
  logic [31:0]      magic_word, magic_word_next;
  logic [15:0]      version_word, version_word_next;
  logic [15:0]      type_word, type_word_next;
  logic [15:0]      status_word, status_word_next;
  logic [31:0]      sequence_word, sequence_word_next;
  logic [31:0]      length_word, length_word_next;
  logic [31:0]      received_check, received_check_next;

  cpd_crc_byte u_crc (
    .crc      (running_crc),
    .data     (rx_byte),
    .crc_next (crc_upd)
  );

  assign count_inc = byte_count + CNT_W'(1);

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    running_crc_next    = running_crc;
    magic_word_next     = magic_word;
    version_word_next   = version_word;
    type_word_next      = type_word;
    status_word_next    = status_word;
    sequence_word_next  = sequence_word;
    length_word_next    = length_word;
    received_check_next = received_check;
    res.valid           = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.payload         = 8'd0;
    res.frame_end       = 1'b0;

    unique case (phase)
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        byte_count_next  = count_inc;
        res.valid        = 1'b1;
        res.payload      = rx_byte;
        if (32'(count_inc) >= length_word) begin
          phase_next      = PH_CHECK;
          byte_count_next = '0;
        end
      end
      PH_CHECK: begin
        received_check_next = {received_check[23:0], rx_byte};
        byte_count_next     = count_inc;
        if (count_inc == CNT_W'(CHECK_BYTES)) begin
          res.valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.kind         = (received_check_next == ~running_crc) ? KIND_OK
                                                                   : KIND_MISMATCH;
          phase_next       = PH_HEADER;
          byte_count_next  = '0;
          running_crc_next = CRC_ONES;
        end
      end
      default: begin
        // unused phase code behaves as header collection
        phase_next       = PH_HEADER;
        running_crc_next = crc_upd;
        if (byte_count < CNT_W'(4)) begin
          magic_word_next = {magic_word[23:0], rx_byte};
        end else if (byte_count < CNT_W'(6)) begin
          version_word_next = {version_word[7:0], rx_byte};
        end else if (byte_count < CNT_W'(8)) begin
          type_word_next = {type_word[7:0], rx_byte};
        end else if (byte_count < CNT_W'(10)) begin
          status_word_next = {status_word[7:0], rx_byte};
        end else if (byte_count < CNT_W'(14)) begin
          sequence_word_next = {sequence_word[23:0], rx_byte};
        end else begin
          length_word_next = {length_word[23:0], rx_byte};
        end
        byte_count_next = count_inc;
        if (count_inc == CNT_W'(HEADER_BYTES)) begin
          if (magic_word_next != expected_magic) begin
            res.valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.kind         = KIND_MAGIC;
            byte_count_next  = '0;
            running_crc_next = CRC_ONES;
          end else if (length_word_next > {15'd0, eff_limit}) begin
            res.valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.kind         = KIND_LENGTH;
            byte_count_next  = '0;
            running_crc_next = CRC_ONES;
          end else begin
            byte_count_next     = '0;
            received_check_next = '0;
            phase_next          = (length_word_next == 32'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
    endcase

    res.version  = version_word_next;
    res.ftype    = type_word_next;
    res.status   = status_word_next;
    res.seqno    = sequence_word_next;
    res.length   = (length_word_next > {15'd0, LEN_CAP}) ? LEN_CAP
                                                         : length_word_next[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_count     <= '0;
      running_crc    <= CRC_ONES;
      magic_word     <= '0;
      version_word   <= '0;
      type_word      <= '0;
      status_word    <= '0;
      sequence_word  <= '0;
      length_word    <= '0;
      received_check <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      running_crc    <= running_crc_next;
      magic_word     <= magic_word_next;
      version_word   <= version_word_next;
      type_word      <= type_word_next;
      status_word    <= status_word_next;
      sequence_word  <= sequence_word_next;
      length_word    <= length_word_next;
      received_check <= received_check_next;
    end
  end

  a_check_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHECK |-> byte_count < CNT_W'(CHECK_BYTES))
    else $error("checksum byte count out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> 32'(byte_count) < length_word)
    else $error("payload count reached length without leaving payload phase");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.frame_end |=> phase == PH_HEADER && byte_count == '0)
    else $error("status result did not restart header collection");

endmodule

/* tb/sv/crc32_packet_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_packet_deframer_tb
// Sends framed byte streams into the deframer: good frames, bad magic, bad
// checksum, over-limit lengths and header noise. Runs them under several
// magic and limit settings, random idling and a long receiver hold-off. A
// byte-level frame predictor checks every forwarded byte and status request.
// ----------------------------------------------------------------------------
module crc32_packet_deframer_tb;
  import cpd_pkg::*;

  localparam int MAX_PAYLOAD = 65536;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES_PER_PHASE = 120;

  typedef enum logic [1:0] {RX_HEADER, RX_PAYLOAD, RX_CHECK} rx_phase_t;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        fend;
    logic [15:0] version;
    logic [15:0] ftype;
    logic [15:0] status;
    logic [31:0] seqno;
    logic [16:0] length;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic [15:0] frame_version;
  logic [15:0] frame_type;
  logic [15:0] frame_status;
  logic [31:0] frame_sequence;
  logic [16:0] frame_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // frame predictor state and register copies
  rx_phase_t   fr_phase;
  logic [16:0] fr_count;
  logic [31:0] fr_crc;
  logic [31:0] fr_magic;
  logic [15:0] fr_version;
  logic [15:0] fr_type;
  logic [15:0] fr_status;
  logic [31:0] fr_sequence;
  logic [31:0] fr_length;
  logic [31:0] fr_check;
  logic [31:0] exp_magic;
  logic [16:0] limit_reg;

  frame_result_t frame_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_left;
  int bytes_sent;
  int failures;

  crc32_packet_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .frame_end     (frame_end),
    .frame_version (frame_version),
    .frame_type    (frame_type),
    .frame_status  (frame_status),
    .frame_sequence(frame_sequence),
    .frame_length  (frame_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] effective_limit();
    logic [31:0] lim;
    lim = (limit_reg > LEN_CAP) ? {15'd0, LEN_CAP} : {15'd0, limit_reg};
    if (MAX_PAYLOAD < lim) begin
      lim = MAX_PAYLOAD;
    end
    return lim;
  endfunction

  function automatic void restart_frame();
    fr_phase = RX_HEADER;
    fr_count = '0;
    fr_crc   = CRC_ONES;
  endfunction

  function automatic void queue_result(input logic [2:0] kind, input logic [7:0] data,
                                       input logic fend);
    frame_result_t r;
    r.kind    = kind;
    r.data    = data;
    r.fend    = fend;
    r.version = fr_version;
    r.ftype   = fr_type;
    r.status  = fr_status;
    r.seqno   = fr_sequence;
    r.length  = (fr_length > LEN_CAP) ? LEN_CAP : fr_length[16:0];
    frame_results.push_back(r);
  endfunction

  function automatic void reset_predictor();
    exp_magic   = MAGIC_RESET;
    limit_reg   = LEN_CAP;
    fr_magic    = '0;
    fr_version  = '0;
    fr_type     = '0;
    fr_status   = '0;
    fr_sequence = '0;
    fr_length   = '0;
    fr_check    = '0;
    restart_frame();
  endfunction

  // advance the frame predictor by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    case (fr_phase)
      RX_PAYLOAD: begin
        fr_crc   = crc32_byte(fr_crc, b);
        fr_count = fr_count + 17'd1;
        queue_result(KIND_PAYLOAD, b, 1'b0);
        if ({15'd0, fr_count} >= fr_length) begin
          fr_phase = RX_CHECK;
          fr_count = '0;
        end
      end
      RX_CHECK: begin
        fr_check = {fr_check[23:0], b};
        fr_count = fr_count + 17'd1;
        if (fr_count == CHECK_BYTES) begin
          queue_result((fr_check == ~fr_crc) ? KIND_OK : KIND_MISMATCH, 8'd0, 1'b1);
          restart_frame();
        end
      end
      default: begin
        fr_phase = RX_HEADER;
        fr_crc   = crc32_byte(fr_crc, b);
        if (fr_count < 4) begin
          fr_magic = {fr_magic[23:0], b};
        end else if (fr_count < 6) begin
          fr_version = {fr_version[7:0], b};
        end else if (fr_count < 8) begin
          fr_type = {fr_type[7:0], b};
        end else if (fr_count < 10) begin
          fr_status = {fr_status[7:0], b};
        end else if (fr_count < 14) begin
          fr_sequence = {fr_sequence[23:0], b};
        end else begin
          fr_length = {fr_length[23:0], b};
        end
        fr_count = fr_count + 17'd1;
        if (fr_count == HEADER_BYTES) begin
          // magic is checked before the length
          if (fr_magic != exp_magic) begin
            queue_result(KIND_MAGIC, 8'd0, 1'b1);
            restart_frame();
          end else if (fr_length > effective_limit()) begin
            queue_result(KIND_LENGTH, 8'd0, 1'b1);
            restart_frame();
          end else begin
            fr_count = '0;
            fr_check = '0;
            fr_phase = (fr_length == 0) ? RX_CHECK : RX_PAYLOAD;
          end
        end
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      rx_valid <= 1'b0;
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // header, then payload and checksum only if the header will pass
  task automatic send_frame(input logic [31:0] magic, input logic [15:0] version,
                            input logic [15:0] ftype, input logic [15:0] status,
                            input logic [31:0] seqno, input logic [31:0] length,
                            input logic crc_bad);
    logic [143:0] hdr;
    logic [7:0]   frame_bytes[$];
    logic [31:0]  crc;
    logic [31:0]  check;
    logic [7:0]   b;
    hdr = {magic, version, ftype, status, seqno, length};
    crc = CRC_ONES;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = hdr[143 - 8 * i -: 8];
      frame_bytes.push_back(b);
      crc = crc32_byte(crc, b);
    end
    if (magic == exp_magic && length <= effective_limit()) begin
      for (int i = 0; i < length; i++) begin
        b = 8'($urandom_range(255));
        frame_bytes.push_back(b);
        crc = crc32_byte(crc, b);
      end
      check = ~crc;
      if (crc_bad) begin
        check = check ^ (32'd1 << $urandom_range(31));
      end
      for (int i = 3; i >= 0; i--) begin
        frame_bytes.push_back(check[8 * i +: 8]);
      end
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  task automatic finish_frame();
    while (fr_phase != RX_HEADER || fr_count != 0) begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // bring the block to idle between frames
  task automatic settle();
    finish_frame();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (frame_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAGIC) begin
      exp_magic = data;
    end else begin
      limit_reg = data[16:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [31:0] limit);
    settle();
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_LIMIT, limit);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic [31:0] lim;
    logic [31:0] len;
    logic [31:0] magic;
    pick  = $urandom_range(99);
    lim   = effective_limit();
    magic = exp_magic;
    len   = $urandom_range(0, (lim < 24) ? lim : 24);
    if (pick < 8) begin
      // truncated header, then realign
      repeat ($urandom_range(1, 17)) send_byte(8'($urandom_range(255)));
      finish_frame();
    end else begin
      if (pick < 11) begin
        magic = exp_magic ^ (32'd1 << $urandom_range(31));
      end else if (pick < 14) begin
        magic = $urandom;
      end else if (pick < 20) begin
        len = $urandom_range(1) ? lim + 1 + $urandom_range(3) : ($urandom | 32'h0002_0000);
      end
      send_frame(magic, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, len,
                 pick >= 20 && pick < 28);
    end
  endtask

  task automatic test_good_frames();
    send_frame(MAGIC_RESET, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 32'd0, 1'b0);
    send_frame(MAGIC_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 1'b0);
    send_frame(MAGIC_RESET, 16'h8001, 16'h7FFE, 16'h5AA5, 32'h8000_0001, 32'd5, 1'b0);
  endtask

  task automatic test_bad_magic();
    send_frame(MAGIC_RESET ^ 32'h1, 16'h1234, 16'h0001, 16'h0002, 32'd7, 32'd3, 1'b0);
    // magic wins over an over-limit length
    send_frame(~MAGIC_RESET, 16'h0001, 16'h0002, 16'h0003, 32'd8, 32'hFFFF_FFFF, 1'b0);
    send_frame(MAGIC_RESET, 16'h0002, 16'h0003, 16'h0004, 32'd9, 32'd2, 1'b0);
  endtask

  task automatic test_bad_checksum();
    send_frame(MAGIC_RESET, 16'h00AA, 16'h0055, 16'h0F0F, 32'd10, 32'd4, 1'b1);
    send_frame(MAGIC_RESET, 16'h00AB, 16'h0056, 16'h0F10, 32'd11, 32'd0, 1'b1);
  endtask

  task automatic test_length_limit();
    send_frame(MAGIC_RESET, 16'h0003, 16'h0004, 16'h0005, 32'd12, 32'd65537, 1'b0);
    send_frame(MAGIC_RESET, 16'h0004, 16'h0005, 16'h0006, 32'd13, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(32'h0000_0000, 32'd0);
    send_frame(32'h0000_0000, 16'h0010, 16'h0020, 16'h0030, 32'd20, 32'd0, 1'b0);
    send_frame(32'h0000_0000, 16'h0011, 16'h0021, 16'h0031, 32'd21, 32'd1, 1'b0);
    // upper bits of the limit write are dropped, above 65536 acts as 65536
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF, 16'h0012, 16'h0022, 16'h0032, 32'd22, 32'd3, 1'b0);
    send_frame(32'hFFFF_FFFF, 16'h0013, 16'h0023, 16'h0033, 32'd23, 32'd65537, 1'b0);
    set_config($urandom, 32'd7);
    send_frame(exp_magic, 16'h0014, 16'h0024, 16'h0035, 32'd24, 32'd7, 1'b0);
    send_frame(exp_magic, 16'h0015, 16'h0025, 16'h0035, 32'd25, 32'd8, 1'b0);
    set_config(MAGIC_RESET, {15'd0, LEN_CAP});
  endtask

  // length 65536, the largest payload cap, one above a limit just below it
  task automatic test_max_payload();
    set_config(exp_magic, 32'd65535);
    send_frame(exp_magic, 16'hC0DE, 16'h0BAD, 16'hF00D, 32'h0001_0000, 32'd65536, 1'b0);
    set_config(exp_magic, {15'd0, LEN_CAP});
  endtask

  task automatic test_backpressure();
    hold_left = 100;
    send_frame(exp_magic, 16'h0042, 16'h0043, 16'h0044, 32'd42, 32'd40, 1'b0);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [31:0] magic, input logic [31:0] limit);
    int target;
    set_config(magic, limit);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = bytes_sent + RANDOM_BYTES_PER_PHASE;
    while (bytes_sent < target) begin
      send_random_frame();
    end
  endtask

  task automatic test_random();
    run_random_phase(0, 0, MAGIC_RESET, {15'd0, LEN_CAP});
    run_random_phase(71, 0, $urandom, $urandom_range(8, 64));
    run_random_phase(0, 71, $urandom, 32'h0001_FFFF);
    run_random_phase(20, 20, MAGIC_RESET, $urandom_range(0, 20));
  endtask

  // receiver side: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    frame_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (frame_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", result_kind);
        failures++;
      end else begin
        want = frame_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("payload_byte", 32'(want.data), 32'(payload_byte));
        check_field("frame_end", 32'(want.fend), 32'(frame_end));
        check_field("frame_version", 32'(want.version), 32'(frame_version));
        check_field("frame_type", 32'(want.ftype), 32'(frame_type));
        check_field("frame_status", 32'(want.status), 32'(frame_status));
        check_field("frame_sequence", want.seqno, frame_sequence);
        check_field("frame_length", 32'(want.length), 32'(frame_length));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rx_valid && !rx_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("crc32_packet_deframer_tb NOT OK");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    rx_valid           = 1'b0;
    rx_byte            = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_MAGIC;
    cfg_data           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left          = 0;
    bytes_sent         = 0;
    failures           = 0;
    reset_predictor();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_good_frames();
    test_bad_magic();
    test_bad_checksum();
    test_length_limit();
    test_config_extremes();
    test_max_payload();
    test_backpressure();
    test_random();
    settle();

    if (failures == 0) begin
      $display("crc32_packet_deframer_tb OK");
    end else begin
      $display("crc32_packet_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
